// ===== rtl/fdss_pkg.sv =====
// Shared types, constants and segment lookup for the four-digit display scanner.
`timescale 1ns / 1ps

package fdss_pkg;

    localparam int unsigned NumDigits = 4;
    localparam int unsigned DigitW    = 4;
    localparam int unsigned FifoDepth = 2;
    localparam int unsigned FifoPtrW  = 1;
    localparam int unsigned FifoCntW  = 2;

    // Reciprocals scaled so that the shifted product is the exact quotient
    // over the whole input range (overshoot stays below one part in the divisor).
    localparam logic [16:0] RecipTenThousand = 17'd107375;  // >> 30, v < 65536
    localparam logic [13:0] RecipThousand    = 14'd8389;    // >> 23, r < 10000
    localparam logic [12:0] RecipHundred     = 13'd5243;    // >> 19, r < 10000
    localparam logic [15:0] RecipTen         = 16'd52429;   // >> 19, r < 10000

    localparam logic [1:0] LastIdx = 2'd3;

    typedef logic [DigitW-1:0]           t_bcd;
    typedef logic [NumDigits*DigitW-1:0] t_bcd_word;  // thousands in the low nibble
    typedef logic [1:0]                  t_digit_idx;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Active-high segments, bit0 = a ... bit6 = g; seven lights g as well.
    function automatic logic [6:0] seg7(input t_bcd d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h47;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/fdss_front.sv =====
// Front end: accept a binary word and split it into four decimal digits over three stages.
`timescale 1ns / 1ps

module fdss_front import fdss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [15:0] i_value,
    input  t_fifo_stat i_fifo_stat,
    output logic       o_push,
    output t_bcd_word  o_bcd
);

    logic        w_en;
    logic [32:0] w_prod_q;
    logic [16:0] w_sub;
    logic [27:0] w_prod_th;
    logic [26:0] w_prod_h;
    logic [29:0] w_prod_t;

    logic        r_s1_valid;
    logic [15:0] r_s1_value;
    logic [2:0]  r_s1_quot;
    logic        r_s2_valid;
    logic [13:0] r_s2_rem;
    logic        r_s3_valid;
    logic [13:0] r_s3_rem;
    logic [3:0]  r_s3_th;
    logic [6:0]  r_s3_hq;
    logic [9:0]  r_s3_tq;

    logic [6:0]  w_d1;
    logic [9:0]  w_d2;
    logic [13:0] w_d3;

    // Whole pipe advances together; it only holds when the queue is full
    assign w_en    = !r_s3_valid || !i_fifo_stat.full;
    assign o_ready = w_en;
    assign o_push  = r_s3_valid && !i_fifo_stat.full;

    // Stage 1: quotient by ten thousand
    assign w_prod_q = 33'(i_value) * 33'(RecipTenThousand);

    // Stage 2: remainder modulo ten thousand
    assign w_sub = 17'(r_s1_value) - (17'(r_s1_quot) * 17'd10000);

    // Stage 3: quotients by thousand, hundred and ten, in parallel
    assign w_prod_th = 28'(r_s2_rem) * 28'(RecipThousand);
    assign w_prod_h  = 27'(r_s2_rem) * 27'(RecipHundred);
    assign w_prod_t  = 30'(r_s2_rem) * 30'(RecipTen);

    // Digits follow from neighbouring quotients
    assign w_d1 = r_s3_hq  - (7'(r_s3_th)  * 7'd10);
    assign w_d2 = r_s3_tq  - (10'(r_s3_hq) * 10'd10);
    assign w_d3 = r_s3_rem - (14'(r_s3_tq) * 14'd10);

    assign o_bcd = {w_d3[3:0], w_d2[3:0], w_d1[3:0], r_s3_th};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_value <= i_value;
            r_s1_quot  <= w_prod_q[32:30];
            r_s2_rem   <= w_sub[13:0];
            r_s3_rem   <= r_s2_rem;
            r_s3_th    <= w_prod_th[26:23];
            r_s3_hq    <= w_prod_h[25:19];
            r_s3_tq    <= w_prod_t[28:19];
        end
    end

endmodule

// ===== rtl/fdss_fifo.sv =====
// Two-entry queue of digit words between the front and back ends.
`timescale 1ns / 1ps

module fdss_fifo import fdss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_bcd_word  i_data,
    input  logic       i_pop,
    output t_bcd_word  o_data,
    output t_fifo_stat o_stat
);

    t_bcd_word           r_mem [FifoDepth];
    logic [FifoPtrW-1:0] r_wr_ptr;
    logic [FifoPtrW-1:0] r_rd_ptr;
    logic [FifoCntW-1:0] r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FifoCntW'(FifoDepth));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/fdss_back.sv =====
// Back end: scan the queued digits out one per cycle, while the receiver is ready, through the output register.
`timescale 1ns / 1ps

module fdss_back import fdss_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_stat i_fifo_stat,
    input  t_bcd_word  i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_digit_enable,
    output logic [6:0] o_segments,
    output logic       o_last_digit
);

    logic       w_load;
    t_bcd       w_digit;
    t_digit_idx r_idx;
    logic       r_valid;
    logic [3:0] r_enable;
    logic [6:0] r_segs;
    logic       r_last;

    assign w_load  = (!r_valid || i_ready) && !i_fifo_stat.empty;
    assign w_digit = i_head[r_idx*DigitW +: DigitW];
    assign o_pop   = w_load && (r_idx == LastIdx);

    assign o_valid        = r_valid;
    assign o_digit_enable = r_enable;
    assign o_segments     = r_segs;
    assign o_last_digit   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= w_load || (r_valid && !i_ready);
            if (w_load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_enable <= 4'b0001 << r_idx;
            r_segs   <= seg7(w_digit);
            r_last   <= (r_idx == LastIdx);
        end
    end

endmodule

// ===== rtl/four_digit_seven_segment_scan_top.sv =====
// Top level of the four-digit multiplexed seven-segment scanner.
//
// Input channel (i_in_valid / o_in_ready / i_value): one 16-bit binary word.
// The value is taken modulo 10000 and split into thousands, hundreds, tens
// and ones; leading zeros are shown, not blanked.
// Output channel (o_out_valid / i_out_ready): four words per input, in scan
// order thousands first; each carries a one-hot display select, the
// active-high segment pattern (bit0 = a) and a last mark on the ones digit.
// The first digit passes the three arithmetic stages and the queue before it
// reaches the output register; the rest follow one a cycle while the receiver
// is ready. Throughput is set by the single output register that sends one
// digit per cycle; the queue fills when inputs come faster than digits drain.
// Reset (synchronous, active low) empties the stages, the queue and the
// output register; nothing else is held.
// When the receiver stalls, the output word holds; the front keeps taking
// inputs until its last stage holds a word and the two-entry queue is full,
// then the whole front holds, bubbles included.
`timescale 1ns / 1ps

module four_digit_seven_segment_scan_top import fdss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_digit_enable,
    output logic [6:0]  o_segments,
    output logic        o_last_digit
);

    // Front to queue
    logic       w_push;
    t_bcd_word  w_push_data;
    // Queue to back, and status seen by both ends
    t_bcd_word  w_head;
    logic       w_pop;
    t_fifo_stat w_fifo_stat;

    // Reduce and split the value; hold while the queue is full and the last stage holds a word
    fdss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_value     (i_value),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_bcd       (w_push_data)
    );

    // Decouple the arithmetic from the scan so each side stalls alone
    fdss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_stat  (w_fifo_stat)
    );

    // Scan the head word digit by digit; drop it after the ones digit
    fdss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_stat    (w_fifo_stat),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_digit_enable (o_digit_enable),
        .o_segments     (o_segments),
        .o_last_digit   (o_last_digit)
    );

endmodule

// ===== rtl/fdss_checker.sv =====
// Port-level checks for the scanner, bound to the top level.
`timescale 1ns / 1ps

module fdss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_digit_enable,
    input logic [6:0] o_segments,
    input logic       o_last_digit
);

    // No word is offered right after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_digit_enable)
            && $stable(o_segments) && $stable(o_last_digit))
        else $error("stalled word changed");

    // Last mark only on the ones display, exactly one display selected
    a_last_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_digit_enable)
            && (o_last_digit == (o_digit_enable == 4'b1000)))
        else $error("bad display select or last mark");

    // Within a run the next digit follows at once on the next display
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_digit |=> o_out_valid
            && (o_digit_enable == ($past(o_digit_enable) << 1)))
        else $error("scan order broken");

endmodule

bind four_digit_seven_segment_scan_top fdss_checker u_fdss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_digit_enable (o_digit_enable),
    .o_segments     (o_segments),
    .o_last_digit   (o_last_digit)
);
